// ===== src/cps_pkg.sv =====
package cps_pkg;

  localparam int unsigned IdBits     = 8;
  localparam int unsigned PrioBits   = 6;
  localparam int unsigned FactorBits = 8;
  localparam int unsigned ProdBits   = FactorBits + PrioBits;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [1:0] IO_KEYBOARD = 2'd0;
  localparam logic [1:0] IO_NETWORK  = 2'd1;
  localparam logic [1:0] IO_DISK     = 2'd2;

  localparam logic [1:0] REG_START_FACTOR  = 2'd0;
  localparam logic [1:0] REG_KEYBOARD_GAIN = 2'd1;
  localparam logic [1:0] REG_NETWORK_GAIN  = 2'd2;
  localparam logic [1:0] REG_DISK_GAIN     = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_POP,
    CELL_INSERT
  } cell_op_e;

  typedef struct packed {
    logic [IdBits-1:0]   id;
    logic [PrioBits-1:0] prio;
  } entry_t;

  typedef struct packed {
    cell_op_e              op;
    logic                  refill;
    logic [FactorBits-1:0] start_factor;
    entry_t                ins;
  } cell_ctrl_t;

  function automatic logic [ProdBits-1:0] scale(input logic [FactorBits-1:0] factor,
                                                input logic [PrioBits-1:0] prio);
    return ProdBits'(factor) * ProdBits'(prio);
  endfunction

endpackage

// ===== src/cps_in_if.sv =====
interface cps_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] new_id;
  logic [5:0] new_priority;
  logic       ends_now;
  logic [1:0] io_kind;

  modport source (output valid, opcode, new_id, new_priority, ends_now, io_kind, input ready);
  modport sink (input valid, opcode, new_id, new_priority, ends_now, io_kind, output ready);
endinterface

// ===== src/cps_out_if.sv =====
interface cps_out_if #(
  parameter int unsigned CreditBits = 24,
  parameter int unsigned CountBits  = 5
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [7:0]            served_id;
  logic [CreditBits-1:0] credits_after;
  logic                  ended;
  logic                  refilled;
  logic [CountBits-1:0]  queued_count;

  modport source (
    output valid, status, served_id, credits_after, ended, refilled, queued_count,
    input ready
  );
  modport sink (
    input valid, status, served_id, credits_after, ended, refilled, queued_count,
    output ready
  );
endinterface

// ===== src/cps_cfg_if.sv =====
interface cps_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/cps_cell.sv =====
module cps_cell #(
  parameter int unsigned Index      = 0,
  parameter int unsigned QueueDepth = 16,
  parameter int unsigned CreditBits = 24,
  localparam int unsigned CountBits = $clog2(QueueDepth + 1)
) (
  input  logic                   clk_i,
  input  cps_pkg::cell_ctrl_t    ctrl_i,
  input  logic [CreditBits-1:0]  ins_cred_i,
  input  logic [CountBits-1:0]   count_i,
  input  cps_pkg::entry_t        prev_entry_i,
  input  logic [CreditBits-1:0]  prev_cred_i,
  input  cps_pkg::entry_t        next_entry_i,
  input  logic [CreditBits-1:0]  next_cred_i,
  input  logic                   found_i,
  input  logic                   live_i,
  output cps_pkg::entry_t        entry_o,
  output logic [CreditBits-1:0]  cred_o,
  output logic                   found_o,
  output logic                   live_o
);
  import cps_pkg::*;

  localparam logic [CreditBits-1:0] CreditMax = {CreditBits{1'b1}};

  entry_t                entry_q, entry_d;
  logic [CreditBits-1:0] cred_q, cred_d;
  logic                  valid;
  logic                  less;
  logic [CreditBits+ProdBits-1:0] refill_wide;
  logic [CreditBits-1:0] refill_cred;

  assign valid = count_i > CountBits'(Index);
  assign less  = !valid || (cred_q < ins_cred_i);

  assign found_o = found_i || less;
  assign live_o  = live_i || (valid && (cred_q != '0));

  assign refill_wide = {{CreditBits{1'b0}}, scale(ctrl_i.start_factor, next_entry_i.prio)};
  assign refill_cred = (refill_wide > {{ProdBits{1'b0}}, CreditMax}) ? CreditMax
                                                                     : refill_wide[CreditBits-1:0];

  always_comb begin
    entry_d = entry_q;
    cred_d  = cred_q;
    case (ctrl_i.op)
      CELL_POP: begin
        entry_d = next_entry_i;
        cred_d  = ctrl_i.refill ? refill_cred : next_cred_i;
      end
      CELL_INSERT: begin
        if (found_i) begin
          entry_d = prev_entry_i;
          cred_d  = prev_cred_i;
        end else if (less) begin
          entry_d = ctrl_i.ins;
          cred_d  = ins_cred_i;
        end
      end
      default: begin
        entry_d = entry_q;
        cred_d  = cred_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    cred_q  <= cred_d;
  end

  assign entry_o = entry_q;
  assign cred_o  = cred_q;

endmodule

// ===== src/credit_priority_scheduler.sv =====
// Credit-ordered process queue built as a row of QUEUE_DEPTH cells, one entry per cell. An add
// goes from acceptance to a result beat through acceptance, credit scaling and an insert step
// in which every cell compares its credits with the new value and the row shifts right behind
// the insertion point. A tick that reinserts its process first shifts the row left (and refills
// it in the same cycle when no queued entry has credits left), then takes the insert step.
// An ending tick, a tick on an empty queue and an add to a full queue skip the insert step.
// The next item is taken once the previous result beat has gone or in the cycle it goes. The
// cell contents are not cleared by reset; the fill count alone marks which cells hold entries.
module credit_priority_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned CREDIT_BITS = 24
) (
  input logic  clk_i,
  input logic  rst_ni,
  cps_in_if.sink   in_i,
  cps_out_if.source out_o,
  cps_cfg_if.sink  cfg_i
);
  import cps_pkg::*;

  localparam int unsigned CountBits = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CREDIT_BITS-1:0] CreditMax = {CREDIT_BITS{1'b1}};

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_INSERT = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CountBits-1:0]  count_q, count_d;
  logic [FactorBits-1:0] start_factor_q, keyboard_gain_q, network_gain_q, disk_gain_q;

  logic                  opcode_q;
  logic [IdBits-1:0]     id_q;
  logic [PrioBits-1:0]   prio_q;
  logic                  ends_q;
  logic [1:0]            kind_q;

  entry_t                ins_entry_q, ins_entry_d;
  logic [CREDIT_BITS-1:0] ins_cred_q, ins_cred_d;

  logic                  out_valid_q, out_valid_d;
  logic [1:0]            res_status_q, res_status_d;
  logic [IdBits-1:0]     res_served_q, res_served_d;
  logic [CREDIT_BITS-1:0] res_cred_q, res_cred_d;
  logic                  res_ended_q, res_ended_d;
  logic                  res_refilled_q, res_refilled_d;
  logic [CountBits-1:0]  res_count_q, res_count_d;

  cell_ctrl_t            ctrl;
  entry_t                cell_entry [QUEUE_DEPTH];
  logic [CREDIT_BITS-1:0] cell_cred [QUEUE_DEPTH];
  logic                  found_in [QUEUE_DEPTH];
  logic                  found_out [QUEUE_DEPTH];
  logic                  live_in [QUEUE_DEPTH];
  logic                  live_out [QUEUE_DEPTH];

  logic                  in_fire;
  logic                  full;
  logic                  head_zero;
  logic                  any_credit;
  logic                  refill;
  logic                  removed;
  logic [CountBits-1:0]  rem_count;
  logic [CREDIT_BITS-1:0] head_dec;
  logic [FactorBits-1:0] gain;
  logic [CREDIT_BITS+ProdBits-1:0] start_wide;
  logic [CREDIT_BITS+ProdBits-1:0] gain_wide;
  logic [CREDIT_BITS-1:0] start_cred;
  logic [CREDIT_BITS-1:0] gain_cred;

  assign in_i.ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_factor_q  <= 8'd20;
      keyboard_gain_q <= 8'd100;
      network_gain_q  <= 8'd70;
      disk_gain_q     <= 8'd20;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_START_FACTOR:  start_factor_q  <= cfg_i.data;
        REG_KEYBOARD_GAIN: keyboard_gain_q <= cfg_i.data;
        REG_NETWORK_GAIN:  network_gain_q  <= cfg_i.data;
        REG_DISK_GAIN:     disk_gain_q     <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      opcode_q <= in_i.opcode;
      id_q     <= in_i.new_id;
      prio_q   <= in_i.new_priority;
      ends_q   <= in_i.ends_now;
      kind_q   <= in_i.io_kind;
    end
  end

  // head of the queue, taken while the row shifts left
  assign full      = count_q == CountBits'(QUEUE_DEPTH);
  assign rem_count = count_q - CountBits'(1);
  assign head_zero = cell_cred[0] == '0;
  assign any_credit = live_out[QUEUE_DEPTH-1];
  assign refill    = head_zero && !any_credit && (rem_count != '0);
  assign removed   = !head_zero && ends_q;
  assign head_dec  = cell_cred[0] - CREDIT_BITS'(!head_zero);

  always_comb begin
    case (kind_q)
      IO_KEYBOARD: gain = keyboard_gain_q;
      IO_NETWORK:  gain = network_gain_q;
      IO_DISK:     gain = disk_gain_q;
      default:     gain = '0;
    endcase
  end

  assign start_wide = {{CREDIT_BITS{1'b0}}, scale(start_factor_q, prio_q)};
  assign start_cred = (start_wide > {{ProdBits{1'b0}}, CreditMax}) ? CreditMax
                                                                   : start_wide[CREDIT_BITS-1:0];
  assign gain_wide  = {{ProdBits{1'b0}}, head_dec}
                    + {{CREDIT_BITS{1'b0}}, scale(gain, cell_entry[0].prio)};
  assign gain_cred  = (gain_wide > {{ProdBits{1'b0}}, CreditMax}) ? CreditMax
                                                                  : gain_wide[CREDIT_BITS-1:0];

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    ins_entry_d    = ins_entry_q;
    ins_cred_d     = ins_cred_q;
    out_valid_d    = out_valid_q && !out_o.ready;
    res_status_d   = res_status_q;
    res_served_d   = res_served_q;
    res_cred_d     = res_cred_q;
    res_ended_d    = res_ended_q;
    res_refilled_d = res_refilled_q;
    res_count_d    = res_count_q;
    ctrl.op           = CELL_HOLD;
    ctrl.refill       = refill;
    ctrl.start_factor = start_factor_q;
    ctrl.ins          = ins_entry_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_d   = STATUS_DONE;
        res_served_d   = '0;
        res_cred_d     = '0;
        res_ended_d    = 1'b0;
        res_refilled_d = 1'b0;
        res_count_d    = count_q;
        state_d        = S_IDLE;
        out_valid_d    = 1'b1;
        if (opcode_q == OP_ADD) begin
          if (full) begin
            res_status_d = STATUS_FULL;
          end else begin
            ins_entry_d.id   = id_q;
            ins_entry_d.prio = prio_q;
            ins_cred_d       = start_cred;
            state_d          = S_INSERT;
            out_valid_d      = 1'b0;
          end
        end else if (count_q == '0) begin
          res_status_d = STATUS_EMPTY;
        end else begin
          ctrl.op        = CELL_POP;
          count_d        = rem_count;
          res_count_d    = rem_count;
          res_served_d   = cell_entry[0].id;
          res_refilled_d = refill;
          if (removed) begin
            res_ended_d = 1'b1;
            res_cred_d  = head_dec;
          end else begin
            res_cred_d  = gain_cred;
            ins_entry_d = cell_entry[0];
            ins_cred_d  = gain_cred;
            state_d     = S_INSERT;
            out_valid_d = 1'b0;
          end
        end
      end
      S_INSERT: begin
        ctrl.op     = CELL_INSERT;
        count_d     = count_q + CountBits'(1);
        res_count_d = count_q + CountBits'(1);
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_entry_q    <= ins_entry_d;
    ins_cred_q     <= ins_cred_d;
    res_status_q   <= res_status_d;
    res_served_q   <= res_served_d;
    res_cred_q     <= res_cred_d;
    res_ended_q    <= res_ended_d;
    res_refilled_q <= res_refilled_d;
    res_count_q    <= res_count_d;
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign found_in[i] = 1'b0;
      assign live_in[i]  = 1'b0;
    end else if (i == 1) begin : g_second
      assign found_in[i] = found_out[i-1];
      assign live_in[i]  = 1'b0;
    end else begin : g_rest
      assign found_in[i] = found_out[i-1];
      assign live_in[i]  = live_out[i-1];
    end

    cps_cell #(
      .Index      (i),
      .QueueDepth (QUEUE_DEPTH),
      .CreditBits (CREDIT_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .ins_cred_i   (ins_cred_q),
      .count_i      (count_q),
      .prev_entry_i ((i == 0) ? ins_entry_q : cell_entry[(i == 0) ? 0 : i-1]),
      .prev_cred_i  ((i == 0) ? ins_cred_q : cell_cred[(i == 0) ? 0 : i-1]),
      .next_entry_i (cell_entry[(i == QUEUE_DEPTH-1) ? i : i+1]),
      .next_cred_i  (cell_cred[(i == QUEUE_DEPTH-1) ? i : i+1]),
      .found_i      (found_in[i]),
      .live_i       (live_in[i]),
      .entry_o      (cell_entry[i]),
      .cred_o       (cell_cred[i]),
      .found_o      (found_out[i]),
      .live_o       (live_out[i])
    );
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = res_status_q;
  assign out_o.served_id     = res_served_q;
  assign out_o.credits_after = res_cred_q;
  assign out_o.ended         = res_ended_q;
  assign out_o.refilled      = res_refilled_q;
  assign out_o.queued_count  = res_count_q;

endmodule

// ===== tb/sv/tb_credit_priority_scheduler.sv =====
`timescale 1ns / 100ps

module tb_credit_priority_scheduler;
  import cps_pkg::*;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CreditBits = 24;
  localparam logic [CreditBits-1:0] CreditMax = '1;
  localparam int WatchdogLimit = 2000;
  localparam int PhaseItems = 125;

  typedef struct packed {
    logic       opcode;
    logic [7:0] id;
    logic [5:0] prio;
    logic       ends;
    logic [1:0] kind;
  } sched_cmd_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [7:0]            served_id;
    logic [CreditBits-1:0] credits_after;
    logic                  ended;
    logic                  refilled;
    logic [4:0]            count;
  } sched_res_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_CHECKED,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    sched_cmd_t cmd;
    logic [4:0] reps;
    logic [1:0] reg_idx;
    logic [7:0] reg_val;
    sched_res_t res;
  } script_row_t;

  localparam sched_cmd_t NoCmd = '0;
  localparam sched_res_t NoRes = '0;

  localparam script_row_t Script [28] = '{
    '{ROW_CHECKED, '{OP_TICK, 8'h00, 6'd0, 1'b1, 2'd3}, 5'd1, REG_START_FACTOR, 8'd0,
      '{STATUS_EMPTY, 8'h00, 24'd0, 1'b0, 1'b0, 5'd0}},
    '{ROW_REG, NoCmd, 5'd0, REG_START_FACTOR, 8'd0, NoRes},
    '{ROW_REG, NoCmd, 5'd0, REG_KEYBOARD_GAIN, 8'd0, NoRes},
    '{ROW_REG, NoCmd, 5'd0, REG_NETWORK_GAIN, 8'd0, NoRes},
    '{ROW_REG, NoCmd, 5'd0, REG_DISK_GAIN, 8'd0, NoRes},
    '{ROW_ITEM, '{OP_ADD, 8'hA5, 6'd5, 1'b0, IO_KEYBOARD}, 5'd1, REG_START_FACTOR, 8'd0, NoRes},
    '{ROW_CHECKED, '{OP_TICK, 8'h00, 6'd0, 1'b1, IO_KEYBOARD}, 5'd1, REG_START_FACTOR, 8'd0,
      '{STATUS_DONE, 8'hA5, 24'd0, 1'b0, 1'b0, 5'd1}},
    '{ROW_ITEM, '{OP_ADD, 8'h5A, 6'd3, 1'b0, IO_DISK}, 5'd1, REG_START_FACTOR, 8'd0, NoRes},
    '{ROW_REG, NoCmd, 5'd0, REG_START_FACTOR, 8'd20, NoRes},
    '{ROW_ITEM, '{OP_TICK, 8'h00, 6'd0, 1'b1, IO_NETWORK}, 5'd1, REG_START_FACTOR, 8'd0, NoRes},
    '{ROW_ITEM, '{OP_TICK, 8'h00, 6'd0, 1'b1, IO_DISK}, 5'd1, REG_START_FACTOR, 8'd0, NoRes},
    '{ROW_REG, NoCmd, 5'd0, REG_KEYBOARD_GAIN, 8'd100, NoRes},
    '{ROW_ITEM, '{OP_TICK, 8'h00, 6'd0, 1'b1, IO_KEYBOARD}, 5'd1, REG_START_FACTOR, 8'd0, NoRes},
    '{ROW_ITEM, '{OP_TICK, 8'h00, 6'd0, 1'b1, IO_KEYBOARD}, 5'd1, REG_START_FACTOR, 8'd0, NoRes},
    '{ROW_REG, NoCmd, 5'd0, REG_START_FACTOR, 8'hFF, NoRes},
    '{ROW_REG, NoCmd, 5'd0, REG_KEYBOARD_GAIN, 8'hFF, NoRes},
    '{ROW_REG, NoCmd, 5'd0, REG_NETWORK_GAIN, 8'hFF, NoRes},
    '{ROW_REG, NoCmd, 5'd0, REG_DISK_GAIN, 8'hFF, NoRes},
    '{ROW_ITEM, '{OP_ADD, 8'h00, 6'd0, 1'b1, 2'd3}, 5'd1, REG_START_FACTOR, 8'd0, NoRes},
    '{ROW_ITEM, '{OP_ADD, 8'hFF, 6'd63, 1'b0, IO_KEYBOARD}, 5'd1, REG_START_FACTOR, 8'd0, NoRes},
    '{ROW_ITEM, '{OP_ADD, 8'h10, 6'd32, 1'b0, IO_KEYBOARD}, 5'd4, REG_START_FACTOR, 8'd0, NoRes},
    '{ROW_ITEM, '{OP_ADD, 8'h20, 6'd1, 1'b0, IO_KEYBOARD}, 5'd4, REG_START_FACTOR, 8'd0, NoRes},
    '{ROW_ITEM, '{OP_ADD, 8'h30, 6'd17, 1'b0, IO_KEYBOARD}, 5'd6, REG_START_FACTOR, 8'd0, NoRes},
    '{ROW_CHECKED, '{OP_ADD, 8'h77, 6'd9, 1'b0, IO_KEYBOARD}, 5'd1, REG_START_FACTOR, 8'd0,
      '{STATUS_FULL, 8'h00, 24'd0, 1'b0, 1'b0, 5'd16}},
    '{ROW_ITEM, '{OP_TICK, 8'h00, 6'd0, 1'b0, 2'd3}, 5'd1, REG_START_FACTOR, 8'd0, NoRes},
    '{ROW_ITEM, '{OP_TICK, 8'h00, 6'd0, 1'b1, IO_DISK}, 5'd1, REG_START_FACTOR, 8'd0, NoRes},
    '{ROW_ITEM, '{OP_TICK, 8'h00, 6'd0, 1'b0, IO_NETWORK}, 5'd1, REG_START_FACTOR, 8'd0, NoRes},
    '{ROW_ITEM, '{OP_TICK, 8'h00, 6'd0, 1'b1, IO_KEYBOARD}, 5'd1, REG_START_FACTOR, 8'd0, NoRes}
  };

  logic clk_i;
  logic rst_ni;

  cps_in_if sched_in ();
  cps_out_if #(.CreditBits(CreditBits), .CountBits(5)) sched_out ();
  cps_cfg_if sched_cfg ();

  credit_priority_scheduler #(
    .QUEUE_DEPTH(QueueDepth),
    .CREDIT_BITS(CreditBits)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (sched_in),
    .out_o (sched_out),
    .cfg_i (sched_cfg)
  );

  // shadow copy of the scheduler queue and its registers
  logic [7:0]            shadow_id   [QueueDepth];
  logic [5:0]            shadow_prio [QueueDepth];
  logic [CreditBits-1:0] shadow_cred [QueueDepth];
  int                    shadow_len = 0;
  logic [7:0]            start_factor = 8'd20;
  logic [7:0]            keyboard_gain = 8'd100;
  logic [7:0]            network_gain = 8'd70;
  logic [7:0]            disk_gain = 8'd20;

  sched_res_t pending_outcomes [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_refill = 0;
  int n_ended = 0;
  int n_saturated = 0;
  int quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [CreditBits-1:0] clamp_credit(input logic [31:0] v);
    return (v > 32'(CreditMax)) ? CreditMax : v[CreditBits-1:0];
  endfunction

  function automatic int idle_entries();
    int i;
    int n;
    n = 0;
    for (i = 0; i < shadow_len; i++) begin
      if (shadow_prio[i] == 6'd0) n++;
    end
    return n;
  endfunction

  function automatic void place_entry(input logic [7:0] id, input logic [5:0] prio,
                                      input logic [CreditBits-1:0] cred);
    int i;
    int pos;
    pos = shadow_len;
    for (i = 0; i < shadow_len; i++) begin
      if (shadow_cred[i] < cred) begin
        pos = i;
        break;
      end
    end
    for (i = shadow_len; i > pos; i--) begin
      shadow_id[i]   = shadow_id[i-1];
      shadow_prio[i] = shadow_prio[i-1];
      shadow_cred[i] = shadow_cred[i-1];
    end
    shadow_id[pos]   = id;
    shadow_prio[pos] = prio;
    shadow_cred[pos] = cred;
    shadow_len++;
  endfunction

  function automatic sched_res_t sched_outcome(input sched_cmd_t c);
    sched_res_t            r;
    logic [7:0]            hid;
    logic [5:0]            hprio;
    logic [CreditBits-1:0] hcred;
    logic [7:0]            gain;
    logic                  any_credit;
    logic                  removed;
    int                    i;
    r = '0;
    if (c.opcode == OP_ADD) begin
      if (shadow_len >= QueueDepth) r.status = STATUS_FULL;
      else place_entry(c.id, c.prio, clamp_credit(32'(start_factor) * 32'(c.prio)));
    end else if (shadow_len == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      hid   = shadow_id[0];
      hprio = shadow_prio[0];
      hcred = shadow_cred[0];
      for (i = 1; i < shadow_len; i++) begin
        shadow_id[i-1]   = shadow_id[i];
        shadow_prio[i-1] = shadow_prio[i];
        shadow_cred[i-1] = shadow_cred[i];
      end
      shadow_len--;
      r.served_id = hid;
      removed = 1'b0;
      if (hcred == '0) begin
        any_credit = 1'b0;
        for (i = 0; i < shadow_len; i++) begin
          if (shadow_cred[i] != '0) any_credit = 1'b1;
        end
        if (!any_credit && shadow_len > 0) begin
          for (i = 0; i < shadow_len; i++) begin
            shadow_cred[i] = clamp_credit(32'(start_factor) * 32'(shadow_prio[i]));
          end
          r.refilled = 1'b1;
        end
      end else begin
        hcred = hcred - CreditBits'(1);
        removed = c.ends;
      end
      if (removed) begin
        r.ended = 1'b1;
        r.credits_after = hcred;
      end else begin
        case (c.kind)
          IO_KEYBOARD: gain = keyboard_gain;
          IO_NETWORK:  gain = network_gain;
          IO_DISK:     gain = disk_gain;
          default:     gain = 8'd0;
        endcase
        hcred = clamp_credit(32'(hcred) + 32'(gain) * 32'(hprio));
        r.credits_after = hcred;
        place_entry(hid, hprio, hcred);
      end
    end
    r.count = 5'(shadow_len);
    return r;
  endfunction

  function automatic sched_cmd_t random_cmd(input int add_pct);
    sched_cmd_t c;
    int pct;
    int pick;
    pct = (shadow_len == 0) ? 80 : (shadow_len >= QueueDepth) ? 25 : add_pct;
    pick = $urandom_range(0, 99);
    c.opcode = ($urandom_range(0, 99) < pct) ? OP_ADD : OP_TICK;
    c.id = 8'($urandom_range(0, 255));
    if (pick < 4 && idle_entries() < 6) c.prio = 6'd0;
    else if (pick < 14) c.prio = 6'($urandom_range(33, 63));
    else c.prio = 6'($urandom_range(1, 32));
    c.ends = ($urandom_range(0, 99) < 35);
    c.kind = 2'($urandom_range(0, 3));
    return c;
  endfunction

  function automatic void flag_field(input string what, input logic [31:0] want,
                                     input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 40)
        $display("%0t %s mismatch: expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  task automatic send_cmd(input sched_cmd_t c, input bit typed, input sched_res_t want,
                          output sched_res_t r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      sched_in.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    sched_in.valid        <= 1'b1;
    sched_in.opcode       <= c.opcode;
    sched_in.new_id       <= c.id;
    sched_in.new_priority <= c.prio;
    sched_in.ends_now     <= c.ends;
    sched_in.io_kind      <= c.kind;
    do @(posedge clk_i); while (!sched_in.ready);
    r = sched_outcome(c);
    if (typed) r = want;
    pending_outcomes.push_back(r);
    beats_in++;
    if (r.status == STATUS_FULL) n_full++;
    if (r.status == STATUS_EMPTY) n_empty++;
    if (r.refilled) n_refill++;
    if (r.ended) n_ended++;
    if (r.credits_after == CreditMax) n_saturated++;
  endtask

  // drop valid and wait until every outstanding beat has come back
  task automatic settle();
    sched_in.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [7:0] val);
    sched_cfg.valid <= 1'b1;
    sched_cfg.index <= idx;
    sched_cfg.data  <= val;
    do @(posedge clk_i); while (!sched_cfg.ready);
    case (idx)
      REG_START_FACTOR:  start_factor = val;
      REG_KEYBOARD_GAIN: keyboard_gain = val;
      REG_NETWORK_GAIN:  network_gain = val;
      default:           disk_gain = val;
    endcase
    sched_cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_script();
    sched_cmd_t c;
    sched_res_t r;
    int k;
    send_idle_pct = 17;
    recv_idle_pct = 50;
    foreach (Script[n]) begin
      if (Script[n].kind == ROW_REG) begin
        settle();
        write_cfg(Script[n].reg_idx, Script[n].reg_val);
      end else begin
        for (k = 0; k < int'(Script[n].reps); k++) begin
          c = Script[n].cmd;
          c.id = Script[n].cmd.id + 8'(k);
          send_cmd(c, Script[n].kind == ROW_CHECKED, Script[n].res, r);
        end
      end
    end
  endtask

  task automatic run_phase(input int ph);
    logic [7:0] vals [4];
    sched_cmd_t c;
    sched_res_t r;
    int add_pct;
    int i;
    settle();
    case (ph / 2)
      0: begin
        send_idle_pct = 17;
        recv_idle_pct = 50;
      end
      1: begin
        send_idle_pct = 50;
        recv_idle_pct = 17;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
    for (i = 0; i < 4; i++) vals[i] = 8'($urandom_range(0, 255));
    case (ph)
      1: vals = '{default: 8'd0};
      2: vals = '{default: 8'hFF};
      4: vals[0] = 8'($urandom_range(0, 3));
      default: ;
    endcase
    for (i = 0; i < 4; i++) write_cfg(2'(i), vals[i]);
    add_pct = $urandom_range(35, 65);
    for (i = 0; i < PhaseItems; i++) begin
      c = random_cmd(add_pct);
      send_cmd(c, 1'b0, NoRes, r);
    end
  endtask

  task automatic check_outcome(input sched_res_t got);
    sched_res_t want;
    if (pending_outcomes.size() == 0) begin
      errors++;
      if (errors <= 40)
        $display("%0t unexpected result beat: expected none, got status %0d id %0d",
                 $time, got.status, got.served_id);
    end else begin
      want = pending_outcomes.pop_front();
      flag_field("status", 32'(want.status), 32'(got.status));
      flag_field("served_id", 32'(want.served_id), 32'(got.served_id));
      flag_field("credits_after", 32'(want.credits_after), 32'(got.credits_after));
      flag_field("ended", 32'(want.ended), 32'(got.ended));
      flag_field("refilled", 32'(want.refilled), 32'(got.refilled));
      flag_field("queued_count", 32'(want.count), 32'(got.count));
    end
  endtask

  initial begin
    sched_res_t got;
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    sched_out.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (sched_out.valid && sched_out.ready) begin
        got.status        = sched_out.status;
        got.served_id     = sched_out.served_id;
        got.credits_after = sched_out.credits_after;
        got.ended         = sched_out.ended;
        got.refilled      = sched_out.refilled;
        got.count         = sched_out.queued_count;
        check_outcome(got);
        beats_out++;
      end
      if (hold_left > 0) begin
        hold_left--;
        sched_out.ready <= 1'b0;
      end else if (!hold_done && beats_out == 60) begin
        hold_left = 100;
        hold_done = 1'b1;
        sched_out.ready <= 1'b0;
      end else begin
        sched_out.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((sched_in.valid && sched_in.ready) || (sched_out.valid && sched_out.ready) ||
          (sched_cfg.valid && sched_cfg.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t no handshake for %0d cycles", $time, WatchdogLimit);
    $display("credit_priority_scheduler test failed");
    $finish;
  end

  initial begin
    int ph;
    sched_in.valid        <= 1'b0;
    sched_in.opcode       <= OP_ADD;
    sched_in.new_id       <= 8'd0;
    sched_in.new_priority <= 6'd0;
    sched_in.ends_now     <= 1'b0;
    sched_in.io_kind      <= IO_KEYBOARD;
    sched_cfg.valid       <= 1'b0;
    sched_cfg.index       <= REG_START_FACTOR;
    sched_cfg.data        <= 8'd0;
    rst_ni                <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_script();
    for (ph = 0; ph < 6; ph++) run_phase(ph);
    settle();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d items and checked %0d results across directed and random runs",
             beats_in, beats_out);
    $display("Seen: %0d full adds, %0d empty ticks, %0d refills, %0d ends, %0d clipped credits",
             n_full, n_empty, n_refill, n_ended, n_saturated);
    if (errors == 0) $display("credit_priority_scheduler test passed");
    else $display("credit_priority_scheduler test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/cps_pkg.sv
src/cps_in_if.sv
src/cps_out_if.sv
src/cps_cfg_if.sv
src/cps_cell.sv
src/credit_priority_scheduler.sv
tb/sv/tb_credit_priority_scheduler.sv
